// ----- src/mep_pkg.sv -----
`default_nettype none
package mep_pkg;

   localparam int MAX_DIM_DEFAULT   = 4096;
   localparam int FRAC_BITS_DEFAULT = 28;

   localparam int POS_W   = 12;
   localparam int DIM_W   = 13;
   localparam int CNT_W   = 16;
   localparam int COLOR_W = 8;
   localparam int CSR_W   = 16;
   localparam int T_W     = 16;

   localparam logic [CSR_W-1:0] DIM_RESET   = 16'd1000;
   localparam logic [CSR_W-1:0] LIMIT_RESET = 16'd1000;

   localparam logic [11:0] K_RED   = 12'd2295;
   localparam logic [11:0] K_GREEN = 12'd3825;
   localparam logic [12:0] K_BLUE  = 13'd4335;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_ITERATION_LIMIT = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ORB_IDLE,
      ORB_MUL,
      ORB_UPD
   } orb_state_type;

   typedef enum logic [3:0] {
      TOP_IDLE,
      TOP_DIVX,
      TOP_DIVY,
      TOP_CWAIT,
      TOP_ORBIT,
      TOP_TDIV,
      TOP_TWAIT,
      TOP_PAL,
      TOP_OUT
   } top_state_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] count;
   } orb_status_type;

endpackage
`default_nettype wire

// ----- src/mep_req_if.sv -----
`default_nettype none
interface mep_req_if;
   logic                      valid;
   logic                      ready;
   logic [mep_pkg::POS_W-1:0] pixel_x;
   logic [mep_pkg::POS_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

// ----- src/mep_rsp_if.sv -----
`default_nettype none
interface mep_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mep_pkg::COLOR_W-1:0] red;
   logic [mep_pkg::COLOR_W-1:0] green;
   logic [mep_pkg::COLOR_W-1:0] blue;
   logic [mep_pkg::CNT_W-1:0]   escape_count;

   modport source (output valid, output red, output green, output blue,
                   output escape_count, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input escape_count, output ready);
endinterface
`default_nettype wire

// ----- src/mep_div_cell.sv -----
`default_nettype none
module mep_div_cell #(
   parameter int DW = 42
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      valid_in,
   input  wire logic [mep_pkg::CSR_W-1:0] rem_in,
   input  wire logic [DW-1:0]             word_in,
   input  wire logic [mep_pkg::CSR_W-1:0] divisor_in,
   output logic                           valid_out,
   output logic [mep_pkg::CSR_W-1:0]      rem_out,
   output logic [DW-1:0]                  word_out,
   output logic [mep_pkg::CSR_W-1:0]      divisor_out
);
   logic                      valid_ff;
   logic [mep_pkg::CSR_W-1:0] rem_ff, rem_in_c;
   logic [DW-1:0]             word_ff, word_in_c;
   logic [mep_pkg::CSR_W-1:0] divisor_ff;
   logic [mep_pkg::CSR_W:0]   trial;
   logic [mep_pkg::CSR_W:0]   diff;
   logic                      take;

   always_comb begin
      trial     = {rem_in, word_in[DW-1]};
      diff      = trial - {1'b0, divisor_in};
      take      = (trial >= {1'b0, divisor_in});
      rem_in_c  = take ? diff[mep_pkg::CSR_W-1:0] : trial[mep_pkg::CSR_W-1:0];
      word_in_c = {word_in[DW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff     <= rem_in_c;
      word_ff    <= word_in_c;
      divisor_ff <= divisor_in;
   end

   assign valid_out   = valid_ff;
   assign rem_out     = rem_ff;
   assign word_out    = word_ff;
   assign divisor_out = divisor_ff;
endmodule
`default_nettype wire

// ----- src/mep_divider.sv -----
`default_nettype none
module mep_divider #(
   parameter int DW = 42
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      valid_in,
   input  wire logic [DW-1:0]             dividend,
   input  wire logic [mep_pkg::CSR_W-1:0] divisor,
   output logic                           valid_out,
   output logic [DW-1:0]                  quotient
);
   logic                      valid_chain   [0:DW];
   logic [mep_pkg::CSR_W-1:0] rem_chain     [0:DW];
   logic [DW-1:0]             word_chain    [0:DW];
   logic [mep_pkg::CSR_W-1:0] divisor_chain [0:DW];

   assign valid_chain[0]   = valid_in;
   assign rem_chain[0]     = '0;
   assign word_chain[0]    = dividend;
   assign divisor_chain[0] = divisor;

   for (genvar i = 0; i < DW; i++) begin : g_cell
      mep_div_cell #(.DW(DW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .valid_in    (valid_chain[i]),
         .rem_in      (rem_chain[i]),
         .word_in     (word_chain[i]),
         .divisor_in  (divisor_chain[i]),
         .valid_out   (valid_chain[i+1]),
         .rem_out     (rem_chain[i+1]),
         .word_out    (word_chain[i+1]),
         .divisor_out (divisor_chain[i+1])
      );
   end

   assign valid_out = valid_chain[DW];
   assign quotient  = word_chain[DW];
endmodule
`default_nettype wire

// ----- src/mep_orbit.sv -----
`default_nettype none
module mep_orbit #(
   parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [FRAC_BITS+3:0] c_re,
   input  wire logic signed [FRAC_BITS+3:0] c_im,
   input  wire logic [mep_pkg::CNT_W-1:0]   limit,
   output mep_pkg::orb_status_type          status
);
   localparam int ZW = FRAC_BITS + 4;
   localparam int PW = 2 * ZW;
   localparam int SW = PW - FRAC_BITS;

   mep_pkg::orb_state_type state_ff, state_in;

   logic signed [ZW-1:0]          zr_ff, zi_ff, cr_ff, ci_ff;
   logic signed [SW-1:0]          sr_ff, si_ff, p_ff;
   logic [mep_pkg::CNT_W-1:0]     count_ff, limit_ff;
   logic signed [PW-1:0]          prod_rr, prod_ii, prod_ri;
   logic [SW:0]                   mag_sum;
   logic [SW:0]                   four;
   logic signed [SW-1:0]          re_next, im_next;
   logic                          at_limit, escaped;
   logic                          load_en, mul_en, upd_en, done;

   always_comb begin
      prod_rr  = zr_ff * zr_ff;
      prod_ii  = zi_ff * zi_ff;
      prod_ri  = zr_ff * zi_ff;
      mag_sum  = {1'b0, sr_ff} + {1'b0, si_ff};
      four     = (SW+1)'(4) << FRAC_BITS;
      escaped  = (mag_sum > four);
      at_limit = (count_ff >= limit_ff);
      re_next  = sr_ff - si_ff + SW'(cr_ff);
      im_next  = (p_ff <<< 1) + SW'(ci_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mep_pkg::ORB_IDLE: begin
            if (start) begin
               state_in = mep_pkg::ORB_MUL;
            end
         end
         mep_pkg::ORB_MUL: begin
            state_in = at_limit ? mep_pkg::ORB_IDLE : mep_pkg::ORB_UPD;
         end
         mep_pkg::ORB_UPD: begin
            state_in = escaped ? mep_pkg::ORB_IDLE : mep_pkg::ORB_MUL;
         end
         default: begin
            state_in = mep_pkg::ORB_IDLE;
         end
      endcase
   end

   always_comb begin
      load_en = 1'b0;
      mul_en  = 1'b0;
      upd_en  = 1'b0;
      done    = 1'b0;
      case (state_ff)
         mep_pkg::ORB_IDLE: begin
            load_en = start;
         end
         mep_pkg::ORB_MUL: begin
            mul_en = !at_limit;
            done   = at_limit;
         end
         mep_pkg::ORB_UPD: begin
            upd_en = !escaped;
            done   = escaped;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mep_pkg::ORB_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (load_en) begin
         zr_ff    <= '0;
         zi_ff    <= '0;
         count_ff <= '0;
         cr_ff    <= c_re;
         ci_ff    <= c_im;
         limit_ff <= limit;
      end
      if (mul_en) begin
         sr_ff <= SW'(prod_rr >>> FRAC_BITS);
         si_ff <= SW'(prod_ii >>> FRAC_BITS);
         p_ff  <= SW'(prod_ri >>> FRAC_BITS);
      end
      if (upd_en) begin
         zr_ff    <= re_next[ZW-1:0];
         zi_ff    <= im_next[ZW-1:0];
         count_ff <= count_ff + 1'b1;
      end
   end

   assign status.done  = done;
   assign status.count = count_ff;
endmodule
`default_nettype wire

// ----- src/mep_palette.sv -----
`default_nettype none
module mep_palette (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [mep_pkg::T_W-1:0]     t,
   output logic                             valid,
   output logic [mep_pkg::COLOR_W-1:0]      red,
   output logic [mep_pkg::COLOR_W-1:0]      green,
   output logic [mep_pkg::COLOR_W-1:0]      blue
);
   logic [16:0]  u;
   logic [31:0]  t2_ff;
   logic [32:0]  tu_ff;
   logic [33:0]  u2_ff;
   logic [63:0]  pr_ff, pg_ff, pb_ff;
   logic [75:0]  r_prod, g_prod;
   logic [76:0]  b_prod;
   logic [mep_pkg::COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic [2:0]   valid_ff;

   always_comb begin
      u      = 17'h10000 - {1'b0, t};
      r_prod = 76'(pr_ff) * 76'(mep_pkg::K_RED);
      g_prod = 76'(pg_ff) * 76'(mep_pkg::K_GREEN);
      b_prod = 77'(pb_ff) * 77'(mep_pkg::K_BLUE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], start};
      end
      t2_ff    <= 32'(t) * 32'(t);
      tu_ff    <= 33'(u) * 33'(t);
      u2_ff    <= 34'(u) * 34'(u);
      pr_ff    <= 64'(tu_ff) * 64'(t2_ff);
      pg_ff    <= 64'(u2_ff) * 64'(t2_ff);
      pb_ff    <= 64'(u2_ff) * 64'(tu_ff);
      red_ff   <= r_prod[71:64];
      green_ff <= g_prod[71:64];
      blue_ff  <= b_prod[72:65];
   end

   assign valid = valid_ff[2];
   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;
endmodule
`default_nettype wire

// ----- src/mandelbrot_escape_pixel_unit.sv -----
`default_nettype none
// Computes one Mandelbrot escape-time pixel per request, one request at a time. The
// coordinate is mapped through a bit-serial divider pipeline of 42 cells with the default
// FRAC_BITS (real and imaginary parts enter on consecutive cycles), each orbit iteration
// has a multiply step (the two squares and the cross product) and an escape test and
// update step, and a colored pixel needs a second pass through the divider plus a
// three-stage palette multiplier. A new request is taken while the previous response
// still waits in the output register.
module mandelbrot_escape_pixel_unit #(
   parameter int MAX_DIM   = mep_pkg::MAX_DIM_DEFAULT,
   parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [1:0]                csr_index,
   input  wire logic [mep_pkg::CSR_W-1:0] csr_write_data,
   mep_req_if.sink                        req_if,
   mep_rsp_if.source                      rsp_if
);
   localparam int ZW    = FRAC_BITS + 4;
   localparam int NUM_W = mep_pkg::POS_W + 2;
   localparam int DW    = (NUM_W + FRAC_BITS > 32) ? NUM_W + FRAC_BITS : 32;

   localparam logic signed [ZW-1:0] RE_ORIGIN = -(ZW'(2) <<< FRAC_BITS);
   localparam logic signed [ZW-1:0] IM_ORIGIN = -(ZW'(3) <<< (FRAC_BITS - 1));

   mep_pkg::top_state_type state_ff, state_in;

   logic [mep_pkg::DIM_W-1:0] width_ff, height_ff;
   logic [mep_pkg::CNT_W-1:0] limit_ff;
   logic [mep_pkg::POS_W-1:0] px_ff, py_ff;
   logic signed [ZW-1:0]      cr_ff, ci_ff;
   logic                      got_x_ff;
   logic [mep_pkg::CNT_W-1:0] count_ff;
   logic [mep_pkg::COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic                      rsp_valid_ff;
   logic [mep_pkg::COLOR_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [mep_pkg::CNT_W-1:0] rsp_count_ff;

   logic                      div_in_valid, div_out_valid;
   logic [DW-1:0]             div_dividend, div_quotient;
   logic [mep_pkg::CSR_W-1:0] div_divisor;
   logic [mep_pkg::DIM_W-1:0] dim_sel, d_sel;
   logic [mep_pkg::POS_W-1:0] pos_sel, pos_sat;
   logic [16:0]               dim_clamp;
   logic [NUM_W-1:0]          num;
   logic signed [ZW-1:0]      coord_val;
   logic                      accept, out_free, orbit_start, pal_start, pal_valid;
   logic                      capture_x, capture_y, capture_count, capture_col, load_out;
   logic [mep_pkg::COLOR_W-1:0] pal_red, pal_green, pal_blue;
   mep_pkg::orb_status_type   orb_status;

   always_comb begin
      dim_sel   = (state_ff == mep_pkg::TOP_DIVX) ? width_ff : height_ff;
      pos_sel   = (state_ff == mep_pkg::TOP_DIVX) ? px_ff : py_ff;
      dim_clamp = 17'(dim_sel);
      if (dim_clamp < 17'd2) begin
         dim_clamp = 17'd2;
      end
      if (dim_clamp > 17'(MAX_DIM)) begin
         dim_clamp = 17'(MAX_DIM);
      end
      d_sel   = mep_pkg::DIM_W'(dim_clamp - 17'd1);
      pos_sat = (mep_pkg::DIM_W'(pos_sel) > d_sel) ? d_sel[mep_pkg::POS_W-1:0] : pos_sel;
      num     = NUM_W'(pos_sat) * NUM_W'(3);
      coord_val = (got_x_ff ? IM_ORIGIN : RE_ORIGIN) + ZW'(div_quotient);
      accept    = req_if.valid && req_if.ready;
      out_free  = !rsp_valid_ff || rsp_if.ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mep_pkg::TOP_IDLE: begin
            if (accept) begin
               state_in = mep_pkg::TOP_DIVX;
            end
         end
         mep_pkg::TOP_DIVX: begin
            state_in = mep_pkg::TOP_DIVY;
         end
         mep_pkg::TOP_DIVY: begin
            state_in = mep_pkg::TOP_CWAIT;
         end
         mep_pkg::TOP_CWAIT: begin
            if (div_out_valid && got_x_ff) begin
               state_in = mep_pkg::TOP_ORBIT;
            end
         end
         mep_pkg::TOP_ORBIT: begin
            if (orb_status.done) begin
               state_in = (orb_status.count < limit_ff) ? mep_pkg::TOP_TDIV : mep_pkg::TOP_OUT;
            end
         end
         mep_pkg::TOP_TDIV: begin
            state_in = mep_pkg::TOP_TWAIT;
         end
         mep_pkg::TOP_TWAIT: begin
            if (div_out_valid) begin
               state_in = mep_pkg::TOP_PAL;
            end
         end
         mep_pkg::TOP_PAL: begin
            if (pal_valid) begin
               state_in = mep_pkg::TOP_OUT;
            end
         end
         mep_pkg::TOP_OUT: begin
            if (out_free) begin
               state_in = mep_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = mep_pkg::TOP_IDLE;
         end
      endcase
   end

   always_comb begin
      req_if.ready  = 1'b0;
      div_in_valid  = 1'b0;
      div_dividend  = DW'(num) << FRAC_BITS;
      div_divisor   = mep_pkg::CSR_W'(d_sel);
      capture_x     = 1'b0;
      capture_y     = 1'b0;
      orbit_start   = 1'b0;
      capture_count = 1'b0;
      pal_start     = 1'b0;
      capture_col   = 1'b0;
      load_out      = 1'b0;
      case (state_ff)
         mep_pkg::TOP_IDLE: begin
            req_if.ready = 1'b1;
         end
         mep_pkg::TOP_DIVX, mep_pkg::TOP_DIVY: begin
            div_in_valid = 1'b1;
         end
         mep_pkg::TOP_CWAIT: begin
            capture_x   = div_out_valid && !got_x_ff;
            capture_y   = div_out_valid && got_x_ff;
            orbit_start = div_out_valid && got_x_ff;
         end
         mep_pkg::TOP_ORBIT: begin
            capture_count = orb_status.done;
         end
         mep_pkg::TOP_TDIV: begin
            div_in_valid = 1'b1;
            div_dividend = DW'(count_ff) << mep_pkg::T_W;
            div_divisor  = limit_ff;
         end
         mep_pkg::TOP_TWAIT: begin
            pal_start = div_out_valid;
         end
         mep_pkg::TOP_PAL: begin
            capture_col = pal_valid;
         end
         mep_pkg::TOP_OUT: begin
            load_out = out_free;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mep_pkg::TOP_IDLE;
         width_ff     <= mep_pkg::DIM_W'(mep_pkg::DIM_RESET);
         height_ff    <= mep_pkg::DIM_W'(mep_pkg::DIM_RESET);
         limit_ff     <= mep_pkg::LIMIT_RESET;
         got_x_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (mep_pkg::csr_index_type'(csr_index))
               mep_pkg::CSR_IMAGE_WIDTH: begin
                  width_ff <= csr_write_data[mep_pkg::DIM_W-1:0];
               end
               mep_pkg::CSR_IMAGE_HEIGHT: begin
                  height_ff <= csr_write_data[mep_pkg::DIM_W-1:0];
               end
               mep_pkg::CSR_ITERATION_LIMIT: begin
                  limit_ff <= csr_write_data;
               end
               default: begin
                  limit_ff <= limit_ff;
               end
            endcase
         end
         if (capture_x) begin
            got_x_ff <= 1'b1;
         end else if (capture_y) begin
            got_x_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         px_ff <= req_if.pixel_x;
         py_ff <= req_if.pixel_y;
      end
      if (capture_x) begin
         cr_ff <= coord_val;
      end
      if (capture_y) begin
         ci_ff <= coord_val;
      end
      if (capture_count) begin
         count_ff <= orb_status.count;
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
      end
      if (capture_col) begin
         red_ff   <= pal_red;
         green_ff <= pal_green;
         blue_ff  <= pal_blue;
      end
      if (load_out) begin
         rsp_red_ff   <= red_ff;
         rsp_green_ff <= green_ff;
         rsp_blue_ff  <= blue_ff;
         rsp_count_ff <= count_ff;
      end
   end

   mep_divider #(.DW(DW)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (div_in_valid),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .valid_out (div_out_valid),
      .quotient  (div_quotient)
   );

   mep_orbit #(.FRAC_BITS(FRAC_BITS)) u_orbit (
      .clock  (clock),
      .reset  (reset),
      .start  (orbit_start),
      .c_re   (cr_ff),
      .c_im   (coord_val),
      .limit  (limit_ff),
      .status (orb_status)
   );

   mep_palette u_palette (
      .clock (clock),
      .reset (reset),
      .start (pal_start),
      .t     (div_quotient[mep_pkg::T_W-1:0]),
      .valid (pal_valid),
      .red   (pal_red),
      .green (pal_green),
      .blue  (pal_blue)
   );

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.red          = rsp_red_ff;
   assign rsp_if.green        = rsp_green_ff;
   assign rsp_if.blue         = rsp_blue_ff;
   assign rsp_if.escape_count = rsp_count_ff;
endmodule
`default_nettype wire
